FILE: hw/rtl/shrf_pkg.sv
// Package for the sliding histogram rank filter.
// Holds payload structs, register indexes, mode codes and defaults; no dependencies.
package shrf_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int BIN_COUNT_DEF  = 256;
   localparam int TOTAL_BITS     = 16;
   localparam int VALUE_BITS     = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [0:0] REG_MODE = 1'b0;
   localparam logic [0:0] REG_RANK = 1'b1;

   localparam logic [1:0] MODE_BOTTOM = 2'd0;
   localparam logic [1:0] MODE_TOP    = 2'd1;
   localparam logic [1:0] MODE_MEDIAN = 2'd2;
   localparam logic [1:0] MODE_DOM    = 2'd3;

   typedef struct packed {
      logic       clear_first;
      logic       remove_valid;
      logic [7:0] remove_value;
      logic       add_valid;
      logic [7:0] add_value;
      logic       emit;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_value;
      logic [15:0] window_total;
   } rsp_type;

endpackage

FILE: hw/rtl/shrf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module shrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

FILE: hw/rtl/shrf_front.sv
// Front end: accepts requests, drops out-of-range values, queues work.
// Uses shrf_pkg.
module shrf_front #(
   parameter int BIN_COUNT = shrf_pkg::BIN_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shrf_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output shrf_pkg::req_type q_data
);
   localparam int PW = $bits(shrf_pkg::req_type);

   logic [PW-1:0] slot_ff [shrf_pkg::QUEUE_DEPTH];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   shrf_pkg::req_type cls;
   logic push, pop;

   // classify: a value beyond the last bin is no update
   always_comb begin
      cls = req_data;
      if ({24'd0, req_data.remove_value} >= BIN_COUNT) cls.remove_valid = 1'b0;
      if ({24'd0, req_data.add_value} >= BIN_COUNT) cls.add_valid = 1'b0;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = slot_ff[rp_ff];
   assign wp_in = wp_ff ^ push;
   assign rp_in = rp_ff ^ pop;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= cls;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> (cnt_ff == 2'd2))
      else $error("full queue lost entry");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 && !push) |=> !q_valid)
      else $error("empty queue produced entry");
endmodule

FILE: hw/rtl/shrf_back.sv
// Back end: clearing pass, bin read-modify-write and rank scan on one RAM.
// Uses shrf_pkg and shrf_ram.
module shrf_back #(
   parameter int COUNT_BITS = shrf_pkg::COUNT_BITS_DEF,
   parameter int BIN_COUNT  = shrf_pkg::BIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  shrf_pkg::req_type q_data,
   input  logic [1:0]        mode,
   input  logic [15:0]       rank_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output shrf_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(BIN_COUNT);
   localparam int AB = AW + 1;
   localparam logic [AB-1:0] NBIN = AB'(BIN_COUNT);
   localparam logic [COUNT_BITS-1:0] BMAX = {COUNT_BITS{1'b1}};
   localparam logic [15:0] TMAX = 16'hFFFF;

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RRD = 4'd2, S_RWR = 4'd3,
                          S_ARD = 4'd4, S_AWR = 4'd5, S_SRD = 4'd6, S_SCAN = 4'd7,
                          S_OUT = 4'd8;

   logic [3:0] st_ff, st_in;
   logic [AB-1:0] idx_ff, idx_in;
   logic [AW-1:0] addr;
   logic we;
   logic [COUNT_BITS-1:0] wd, rd;
   shrf_pkg::req_type it_ff, it_in;
   logic [15:0] tot_ff, tot_in;
   logic [COUNT_BITS+8:0] acc_ff, acc_in, acc_nx;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic [7:0] bidx_ff, bidx_in, res_ff, res_in;
   logic [16:0] target;
   logic down;
   logic [AW-1:0] cur;
   logic ovalid_ff, ovalid_in;
   shrf_pkg::rsp_type out_ff, out_in;

   shrf_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wd), .rd_data(rd));

   assign down = (mode == shrf_pkg::MODE_TOP);
   assign target = (mode == shrf_pkg::MODE_MEDIAN) ? {2'b0, tot_ff[15:1]} : {1'b0, rank_count};
   // scan position of the bin whose read data is now on rd
   assign cur = down ? AW'(NBIN - 1'b1 - idx_ff) : idx_ff[AW-1:0];
   assign acc_nx = acc_ff + (COUNT_BITS+9)'(rd);
   assign q_ready = (st_ff == S_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; it_in = it_ff; tot_in = tot_ff;
      acc_in = acc_ff; best_in = best_ff; bidx_in = bidx_ff; res_in = res_ff;
      ovalid_in = ovalid_ff; out_in = out_ff; we = 1'b0; wd = rd; addr = '0;
      if (ovalid_ff && rsp_ready) ovalid_in = 1'b0;
      case (st_ff)
         S_CLR: begin
            // held item (empty after reset) continues once all bins are zero
            addr = idx_ff[AW-1:0]; we = 1'b1; wd = '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == NBIN - 1'b1) st_in = S_RRD;
         end
         S_IDLE: begin
            if (q_valid) begin
               it_in = q_data;
               if (q_data.clear_first) begin
                  tot_in = '0; idx_in = '0; it_in.clear_first = 1'b0; st_in = S_CLR;
               end else st_in = S_RRD;
               if (q_data.clear_first) st_in = S_CLR;
            end
         end
         S_RRD: begin
            addr = it_ff.remove_value[AW-1:0];
            st_in = it_ff.remove_valid ? S_RWR : S_ARD;
         end
         S_RWR: begin
            addr = it_ff.remove_value[AW-1:0];
            if (rd != '0) begin
               we = 1'b1; wd = rd - 1'b1;
               if (tot_ff != '0) tot_in = tot_ff - 1'b1;
            end
            st_in = S_ARD;
         end
         S_ARD: begin
            addr = it_ff.add_value[AW-1:0];
            st_in = it_ff.add_valid ? S_AWR : S_SRD;
         end
         S_AWR: begin
            addr = it_ff.add_value[AW-1:0];
            if (rd != BMAX) begin
               we = 1'b1; wd = rd + 1'b1;
               if (tot_ff != TMAX) tot_in = tot_ff + 1'b1;
            end
            st_in = S_SRD;
         end
         S_SRD: begin
            // start scan; rank of zero ends at once
            idx_in = '0; acc_in = '0; best_in = '0; bidx_in = '0;
            addr = down ? AW'(NBIN - 1'b1) : '0;
            if (!it_ff.emit) st_in = S_IDLE;
            else if (mode != shrf_pkg::MODE_DOM && target == '0) begin
               res_in = down ? 8'(NBIN - 1'b1) : 8'd0; st_in = S_OUT;
            end else st_in = S_SCAN;
         end
         S_SCAN: begin
            acc_in = acc_nx;
            idx_in = idx_ff + 1'b1;
            addr = down ? AW'(NBIN - 2'd2 - idx_ff) : AW'(idx_ff + 1'b1);
            if (mode == shrf_pkg::MODE_DOM) begin
               if (idx_ff == '0 || rd > best_ff) begin
                  best_in = rd; bidx_in = 8'(cur);
               end
               if (idx_ff == NBIN - 1'b1) begin
                  res_in = (idx_ff == '0 || rd > best_ff) ? 8'(cur) : bidx_ff;
                  st_in = S_OUT;
               end
            end else if (acc_nx >= (COUNT_BITS+9)'(target)) begin
               res_in = 8'(cur); st_in = S_OUT;
            end else if (idx_ff == NBIN - 1'b1) begin
               res_in = down ? 8'd0 : 8'(NBIN - 1'b1); st_in = S_OUT;
            end
         end
         S_OUT: begin
            // result and total move together into the output register
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in = 1'b1; st_in = S_IDLE;
               out_in = '{result_value: res_ff, window_total: tot_ff};
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; idx_ff <= '0; tot_ff <= '0; ovalid_ff <= 1'b0; it_ff <= '0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; tot_ff <= tot_in; ovalid_ff <= ovalid_in;
         it_ff <= it_in;
      end
      acc_ff <= acc_in; best_ff <= best_in;
      bidx_ff <= bidx_in; res_ff <= res_in; out_ff <= out_in;
   end

   a_take: assert property (@(posedge clock) disable iff (reset)
      (q_ready && q_valid) |=> (st_ff != S_IDLE))
      else $error("accepted item not started");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_ff)))
      else $error("result dropped under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLR) |-> !q_ready)
      else $error("ready during clear pass");
endmodule

FILE: hw/rtl/sliding_histogram_rank_filter.sv
// Sliding histogram rank filter: configuration registers, front queue, back end.
// Uses shrf_pkg, shrf_front, shrf_back.
//
// Keeps a count histogram in one single-port RAM. After reset a clearing pass writes one
// bin a cycle over all BIN_COUNT bins (256 by default), and the back end steps through
// S_RRD, S_ARD and S_SRD before the first item is taken. An item with clear_first runs
// the same pass before its updates. An item holds the back end while each remove or add
// it carries does a read and a write on the single RAM port. An emit adds a scan of up
// to BIN_COUNT bins, one bin read per cycle, and then loads the result register, where
// the result waits while the result side stalls. A two-entry queue ahead of the back
// end and the result register let both sides stall on their own.
module sliding_histogram_rank_filter #(
   parameter int COUNT_BITS = shrf_pkg::COUNT_BITS_DEF,
   parameter int BIN_COUNT  = shrf_pkg::BIN_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  shrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output shrf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_data
);
   logic [1:0] mode_ff;
   logic [15:0] rank_ff;
   logic q_valid, q_ready;
   shrf_pkg::req_type q_data;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= shrf_pkg::MODE_MEDIAN; rank_ff <= 16'd1;
      end else if (csr_valid) begin
         if (csr_index == shrf_pkg::REG_MODE) mode_ff <= csr_data[1:0];
         if (csr_index == shrf_pkg::REG_RANK) rank_ff <= csr_data;
      end
   end

   shrf_front #(.BIN_COUNT(BIN_COUNT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data);

   shrf_back #(.COUNT_BITS(COUNT_BITS), .BIN_COUNT(BIN_COUNT)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .mode(mode_ff), .rank_count(rank_ff), .rsp_valid, .rsp_ready, .rsp_data);
endmodule
